### hw/rtl/ppc_pkg.sv
// ============================================================================
// ppc_pkg - shared types and constants for the polygon plane clipper
// Holds the controller states, command and status structs and field widths.
// ============================================================================
package ppc_pkg;

  localparam int CoordW = 32;
  localparam int IdxW   = 16;
  localparam int NrmW   = 18;
  localparam int ThrW   = 16;
  localparam int DistW  = 68;
  localparam int FracW  = 30;
  localparam int OutCap = 32;

  localparam logic [2:0] RegNormalX = 3'd0;
  localparam logic [2:0] RegNormalY = 3'd1;
  localparam logic [2:0] RegNormalZ = 3'd2;
  localparam logic [2:0] RegOffset  = 3'd3;
  localparam logic [2:0] RegThresh  = 3'd4;

  localparam logic [1:0] ClsFront    = 2'd0;
  localparam logic [1:0] ClsBack     = 2'd1;
  localparam logic [1:0] ClsCoplanar = 2'd2;
  localparam logic [1:0] ClsSplit    = 2'd3;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DOT,
    ST_CLASSIFY,
    ST_DECIDE,
    ST_READ,
    ST_EVAL,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_EMIT_X,
    ST_EMIT_V,
    ST_EMIT_MARK,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic       load;     // capture the incoming vertex
    logic       dot;      // form the partial products
    logic       classify; // finish the distance, write the store
    logic       rd;       // read the ring at cur and prev
    logic       div_go;   // start the fraction divider
    logic       mul;      // form |b-a|*t products
    logic       sum;      // finish interpolation
    logic       emit_x;   // output register gets the intersection
    logic       emit_v;   // output register gets the stored vertex
    logic       emit_m;   // output register gets the empty marker
    logic       last;     // last_out for the item being emitted
    logic [1:0] cls;      // classification being emitted
    logic       clear;    // polygon done
  } ppc_cmd_t;

  typedef struct packed {
    logic       side_cur;
    logic       side_prev;
    logic       div_done;
    logic       seen_front;
    logic       seen_back;
    logic       tail_back;  // no front vertex at or after cur
  } ppc_sts_t;

endpackage

### hw/rtl/polygon_plane_clip_top.sv
// ============================================================================
// polygon_plane_clip_top - single plane polygon clipper
// Loads a polygon, classifies it against a plane and emits what it keeps.
// ============================================================================
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tdata: vertex, tlast: last_vertex
//  out_    | out | out_tvalid/out_tready | tdata: vertex, tuser: flags, tlast
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_addr index, cfg_data value
//
// Each vertex is loaded in three steps (capture, dot product, store). A front
// or coplanar polygon is then emitted whole and a back one as an empty marker.
// In a split, back vertices are dropped and front ones kept; each crossing
// adds an intersection from the one-bit-per-cycle fraction divider, emitted
// before the vertex it leads to. Each polygon adds a decide and a finish step.
// Reset is synchronous and clears control state; the store needs no clearing.
// A stalled output holds the sequencer; input waits until the polygon is done.
module polygon_plane_clip_top
  import ppc_pkg::*;
#(
  parameter int MAX_VERTICES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, uv_u, uv_v, source_index
  input  logic [175:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z, out_u, out_v, out_index
  output logic [175:0] out_tdata,
  // vertex_valid, classification
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  localparam int CntW  = $clog2(MAX_VERTICES + 1);
  localparam int AddrW = $clog2(MAX_VERTICES);

  ppc_cmd_t        cmd;
  ppc_sts_t        sts;
  logic [CntW-1:0] vcount, cur, prv;
  logic            out_busy;
  logic [179:0]    item;
  logic            ovalid_r;

  assign cfg_ready = 1'b1;

  // The output valid follows the datapath's output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.emit_x || cmd.emit_v || cmd.emit_m) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = item[175:0];
  assign out_tuser  = item[178:176];
  assign out_tlast  = item[179];

  ppc_ctrl #(.CntW(CntW)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && in_tready),
    .in_last (in_tlast),
    .vcount  (vcount),
    .sts     (sts),
    .out_busy(out_busy),
    .in_ready(in_tready),
    .cur     (cur),
    .prv     (prv),
    .cmd     (cmd)
  );

  ppc_dp #(.MaxV(MAX_VERTICES), .CntW(CntW), .AddrW(AddrW)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid),
    .cfg_idx (cfg_addr),
    .cfg_dat (cfg_data),
    .in_vtx  (in_tdata),
    .cmd     (cmd),
    .cur     (cur),
    .prv     (prv),
    .out_take(ovalid_r && out_tready),
    .vcount  (vcount),
    .sts     (sts),
    .out_busy(out_busy),
    .out_item(item)
  );

endmodule

### hw/rtl/ppc_ctrl.sv
// ============================================================================
// ppc_ctrl - clipper sequencer
// Walks load, classification and the clip pass, and paces the output register.
// ============================================================================
module ppc_ctrl
  import ppc_pkg::*;
#(
  parameter int CntW = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic            in_last,
  input  logic [CntW-1:0] vcount,
  input  ppc_sts_t        sts,
  input  logic            out_busy,
  output logic            in_ready,
  output logic [CntW-1:0] cur,
  output logic [CntW-1:0] prv,
  output ppc_cmd_t        cmd
);

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cur_r, cur_nxt, prv_r, prv_nxt;
  logic [5:0]      ocnt_r, ocnt_nxt;
  logic            last_r, last_nxt;
  logic [1:0]      cls_r, cls_nxt;
  logic            vpend_r, vpend_nxt;

  assign cur = cur_r;
  assign prv = prv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cur_r   <= '0;
      prv_r   <= '0;
      ocnt_r  <= '0;
      last_r  <= 1'b0;
      cls_r   <= ClsFront;
      vpend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      prv_r   <= prv_nxt;
      ocnt_r  <= ocnt_nxt;
      last_r  <= last_nxt;
      cls_r   <= cls_nxt;
      vpend_r <= vpend_nxt;
    end
  end

  logic            at_end;
  logic [CntW-1:0] cur_inc;
  logic            cap_hit;
  assign cur_inc = cur_r + 1'b1;
  assign at_end  = (cur_inc == vcount);
  assign cap_hit = (ocnt_r == 6'(OutCap - 1));

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    prv_nxt   = prv_r;
    ocnt_nxt  = ocnt_r;
    last_nxt  = last_r;
    cls_nxt   = cls_r;
    vpend_nxt = vpend_r;
    cmd       = '0;
    cmd.cls   = cls_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load  = 1'b1;
          last_nxt  = in_last;
          state_nxt = ST_DOT;
        end
      end
      ST_DOT: begin
        cmd.dot   = 1'b1;
        state_nxt = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        cmd.classify = 1'b1;
        state_nxt    = last_r ? ST_DECIDE : ST_LOAD;
      end
      ST_DECIDE: begin
        ocnt_nxt = '0;
        cur_nxt  = '0;
        prv_nxt  = vcount - 1'b1;
        if (!sts.seen_front) begin
          cls_nxt   = sts.seen_back ? ClsBack : ClsCoplanar;
          state_nxt = sts.seen_back ? ST_EMIT_MARK : ST_READ;
        end else begin
          cls_nxt   = sts.seen_back ? ClsSplit : ClsFront;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (cls_r != ClsSplit) begin
          if (!out_busy) begin
            cmd.emit_v = 1'b1;
            cmd.last   = at_end;
            cur_nxt    = cur_inc;
            state_nxt  = at_end ? ST_WAIT : ST_READ;
          end
        end else if (sts.side_cur != sts.side_prev) begin
          cmd.div_go = 1'b1;
          vpend_nxt  = !sts.side_prev;
          state_nxt  = ST_DIV;
        end else if (sts.side_cur) begin
          vpend_nxt = 1'b1;
          state_nxt = ST_EMIT_V;
        end else begin
          prv_nxt   = cur_r;
          cur_nxt   = cur_inc;
          state_nxt = at_end ? ST_WAIT : ST_READ;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_EMIT_X;
      end
      ST_EMIT_X: begin
        if (!out_busy) begin
          cmd.emit_x = 1'b1;
          // A front-to-back crossing with only back vertices left is the final item.
          cmd.last   = cap_hit || (!vpend_r && sts.tail_back);
          ocnt_nxt   = ocnt_r + 1'b1;
          if (cap_hit) begin
            state_nxt = ST_WAIT;
          end else if (vpend_r) begin
            state_nxt = ST_EMIT_V;
          end else begin
            prv_nxt   = cur_r;
            cur_nxt   = cur_inc;
            state_nxt = at_end ? ST_WAIT : ST_READ;
          end
        end
      end
      ST_EMIT_V: begin
        if (!out_busy) begin
          cmd.emit_v = 1'b1;
          cmd.last   = cap_hit || at_end;
          ocnt_nxt   = ocnt_r + 1'b1;
          vpend_nxt  = 1'b0;
          prv_nxt    = cur_r;
          cur_nxt    = cur_inc;
          state_nxt  = (cap_hit || at_end) ? ST_WAIT : ST_READ;
        end
      end
      ST_EMIT_MARK: begin
        if (!out_busy) begin
          cmd.emit_m = 1'b1;
          cmd.last   = 1'b1;
          state_nxt  = ST_WAIT;
        end
      end
      ST_WAIT: begin
        cmd.clear = 1'b1;
        state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule

### hw/rtl/ppc_div.sv
// ============================================================================
// ppc_div - fraction divider
// Restoring division giving num/den as unsigned Q1.30, one bit per cycle.
// ============================================================================
module ppc_div
  import ppc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DistW-1:0] num,
  input  logic [DistW-1:0] den,
  output logic             done,
  output logic [FracW:0]   quo
);

  logic [DistW:0]   rem_r, rem_nxt;
  logic [DistW-1:0] den_r;
  logic [FracW:0]   q_r, q_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DistW:0]   sh;

  assign done = busy_r && (cnt_r == 5'd0);
  assign quo  = q_r;
  assign sh   = {rem_r[DistW-1:0], 1'b0};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(FracW);
      if ({1'b0, num} >= {1'b0, den}) begin
        rem_nxt = {1'b0, num} - {1'b0, den};
        q_nxt   = (FracW+1)'(1);
      end else begin
        rem_nxt = {1'b0, num};
        q_nxt   = '0;
      end
    end else if (busy_r) begin
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        if (sh >= {1'b0, den_r}) begin
          rem_nxt = sh - {1'b0, den_r};
          q_nxt   = {q_r[FracW-1:0], 1'b1};
        end else begin
          rem_nxt = sh;
          q_nxt   = {q_r[FracW-1:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (go) den_r <= den;
  end

endmodule

### hw/rtl/ppc_dp.sv
// ============================================================================
// ppc_dp - clipper datapath
// Vertex store, plane distance, interpolation and the output register.
// ============================================================================
module ppc_dp
  import ppc_pkg::*;
#(
  parameter int MaxV = 16,
  parameter int CntW = 5,
  parameter int AddrW = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [31:0]       cfg_dat,
  input  logic [5*CoordW+IdxW-1:0] in_vtx,
  input  ppc_cmd_t          cmd,
  input  logic [CntW-1:0]   cur,
  input  logic [CntW-1:0]   prv,
  input  logic              out_take,
  output logic [CntW-1:0]   vcount,
  output ppc_sts_t          sts,
  output logic              out_busy,
  output logic [5*CoordW+IdxW+3:0] out_item
);

  localparam int VW = 5*CoordW + IdxW;

  logic signed [NrmW-1:0]   nx_r, ny_r, nz_r;
  logic signed [CoordW-1:0] off_r;
  logic [ThrW-1:0]          thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= NrmW'(65536);
      off_r <= '0;
      thr_r <= ThrW'(6554);
    end else if (cfg_we) begin
      case (cfg_idx)
        RegNormalX: nx_r  <= cfg_dat[NrmW-1:0];
        RegNormalY: ny_r  <= cfg_dat[NrmW-1:0];
        RegNormalZ: nz_r  <= cfg_dat[NrmW-1:0];
        RegOffset:  off_r <= cfg_dat;
        RegThresh:  thr_r <= cfg_dat[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Incoming vertex and distance pipeline.
  logic [VW-1:0]           vin_r;
  logic signed [50:0]      px_r, py_r, pz_r;
  logic signed [DistW-1:0] vdist;
  logic                    full;

  assign full = (vcount == CntW'(MaxV));
  assign vdist = DistW'(px_r) + DistW'(py_r) + DistW'(pz_r)
               - {{(DistW-48){off_r[CoordW-1]}}, off_r, 16'd0};

  always_ff @(posedge clk) begin
    if (cmd.load) vin_r <= in_vtx;
    if (cmd.dot) begin
      px_r <= $signed(vin_r[CoordW-1:0]) * nx_r;
      py_r <= $signed(vin_r[2*CoordW-1:CoordW]) * ny_r;
      pz_r <= $signed(vin_r[3*CoordW-1:2*CoordW]) * nz_r;
    end
  end

  // Vertex store; read registered at cur and prev.
  logic [VW-1:0]    vmem [MaxV];
  logic [DistW-1:0] dmem [MaxV];
  logic [VW-1:0]    va_r, vb_r;
  logic [DistW-1:0] da_r, db_r;

  always_ff @(posedge clk) begin
    if (cmd.classify && !full) begin
      vmem[vcount[AddrW-1:0]] <= vin_r;
      dmem[vcount[AddrW-1:0]] <= vdist;
    end
    if (cmd.rd) begin
      vb_r <= vmem[cur[AddrW-1:0]];
      db_r <= dmem[cur[AddrW-1:0]];
      va_r <= vmem[prv[AddrW-1:0]];
      da_r <= dmem[prv[AddrW-1:0]];
    end
  end

  logic [CntW-1:0] vcount_r;
  logic [CntW-1:0] lastf_r;
  logic            sf_r, sb_r;
  logic signed [DistW-1:0] thr_s;
  assign thr_s  = DistW'({thr_r, 16'd0});
  assign vcount = vcount_r;

  // lastf_r keeps the index of the most recent front-side vertex of the polygon.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vcount_r <= '0;
      lastf_r  <= '0;
      sf_r     <= 1'b0;
      sb_r     <= 1'b0;
    end else if (cmd.classify && !full) begin
      vcount_r <= vcount_r + 1'b1;
      if (!vdist[DistW-1]) lastf_r <= vcount_r;
      if (vdist > thr_s)  sf_r <= 1'b1;
      if (vdist < -thr_s) sb_r <= 1'b1;
    end
  end

  // Fraction t = |d1| / |d1 - d2|.
  logic [DistW-1:0] dnum, dden, ddiff;
  logic [FracW:0]   t;
  logic             ddone;
  assign ddiff = da_r - db_r;
  assign dnum  = da_r[DistW-1] ? -da_r : da_r;
  assign dden  = ddiff[DistW-1] ? -ddiff : ddiff;

  ppc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.div_go),
    .num  (dnum),
    .den  (dden),
    .done (ddone),
    .quo  (t)
  );

  assign sts.side_cur   = !db_r[DistW-1];
  assign sts.side_prev  = !da_r[DistW-1];
  assign sts.div_done   = ddone;
  assign sts.seen_front = sf_r;
  assign sts.seen_back  = sb_r;
  assign sts.tail_back  = (cur > lastf_r);

  // Interpolation: five lanes, each a + sign * trunc(|b - a| * t).
  logic [64:0] prod_r [5];
  logic        neg_r  [5];
  logic [CoordW-1:0] ires_r [5];

  for (genvar g = 0; g < 5; g++) begin : g_lane
    logic signed [CoordW:0] df;
    logic [CoordW:0]        mg;
    assign df = $signed({va_r[g*CoordW+CoordW-1], va_r[g*CoordW +: CoordW]});
    always_comb begin
      mg = $unsigned($signed({vb_r[g*CoordW+CoordW-1], vb_r[g*CoordW +: CoordW]}) - df);
      if (mg[CoordW]) mg = -mg;
    end
    always_ff @(posedge clk) begin
      if (cmd.mul) begin
        prod_r[g] <= 65'(mg[CoordW-1:0]) * 65'(t) + (mg[CoordW] ? 65'(t) << CoordW : 65'd0);
        neg_r[g]  <= ($signed({vb_r[g*CoordW+CoordW-1], vb_r[g*CoordW +: CoordW]}) - df) < 0;
      end
      if (cmd.sum) begin
        ires_r[g] <= neg_r[g] ? va_r[g*CoordW +: CoordW] - prod_r[g][FracW +: CoordW]
                              : va_r[g*CoordW +: CoordW] + prod_r[g][FracW +: CoordW];
      end
    end
  end

  // Output register: {last, cls, valid, index, v, u, z, y, x}.
  logic             ov_r;
  logic [VW+3:0]    od_r;
  assign out_busy = ov_r && !out_take;
  assign out_item = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_x || cmd.emit_v || cmd.emit_m) begin
      ov_r <= 1'b1;
    end else if (out_take) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_x) begin
      od_r <= {cmd.last, cmd.cls, 1'b1, vb_r[VW-1 -: IdxW],
               ires_r[4], ires_r[3], ires_r[2], ires_r[1], ires_r[0]};
    end else if (cmd.emit_v) begin
      od_r <= {cmd.last, cmd.cls, 1'b1, vb_r};
    end else if (cmd.emit_m) begin
      od_r <= {1'b1, ClsBack, 1'b0, {VW{1'b0}}};
    end
  end

endmodule

### hw/rtl/ppc_checker.sv
// ============================================================================
// ppc_checker - port level checks for the clipper
// Watches the handshakes and the framing of result items.
// ============================================================================
module ppc_checker
  import ppc_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [175:0] out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tlast
);

  // An empty marker always closes the polygon as a back result.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && out_tuser[2:1] == ClsBack))
    else $error("empty marker malformed");

  // An accepted vertex closes the input, so no two vertices are accepted back to back.
  a_noin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted back to back");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output changed");

endmodule

bind polygon_plane_clip_top ppc_checker u_ppc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

### verif/testbench.sv
// ============================================================================
// testbench - self-checking bench for the single plane polygon clipper
// Drives polygons and plane settings, predicts every emitted item with an
// in-bench clip model and compares each item field by field.
// ============================================================================
module testbench
  import ppc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxVerts  = 16;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic [15:0] idx;
    logic [31:0] v;
    logic [31:0] u;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } vertex_t;

  typedef struct {
    vertex_t    vtx;
    logic       valid;
    logic [1:0] cls;
    logic       last;
  } clip_item_t;

  typedef struct {
    vertex_t vtx;
    logic    last;
  } vert_in_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [175:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [175:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_addr;
  logic [31:0]  cfg_data;

  polygon_plane_clip_top dut (.*);

  // Plane registers and polygon state of the prediction.
  logic signed [17:0] plane_nx, plane_ny, plane_nz;
  logic signed [31:0] plane_off;
  logic        [15:0] plane_thr;
  vertex_t            ring_vtx [MaxVerts];
  logic signed [67:0] ring_dist [MaxVerts];
  logic               ring_side [MaxVerts];
  int                 ring_count;
  logic               any_front, any_back;

  clip_item_t pending_items[$];
  vert_in_t   vertex_queue[$];
  int         error_count;
  int         items_checked;
  int         idle_cycles;
  int         polygons_sent;
  int         splits_seen;
  logic       long_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Restoring division to a Q1.30 fraction; num never exceeds den.
  function automatic logic [30:0] frac_of(logic [67:0] num, logic [67:0] den);
    logic [68:0] rem;
    logic [30:0] q;
    rem = {1'b0, num};
    q = '0;
    if (rem >= den) begin
      q = 31'd1;
      rem = rem - den;
    end
    for (int i = 0; i < FracW; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Moves from a toward b by the fraction t, always landing between the two.
  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [30:0] t);
    logic signed [33:0] diff;
    logic [33:0] mag;
    logic [64:0] prod;
    logic signed [33:0] step;
    diff = $signed({{2{b[31]}}, b}) - $signed({{2{a[31]}}, a});
    mag = diff[33] ? -diff : diff;
    prod = (65'(mag) * 65'(t)) >> FracW;
    step = prod[33:0];
    if (diff[33])
      return 32'($signed({{2{a[31]}}, a}) - step);
    return 32'($signed({{2{a[31]}}, a}) + step);
  endfunction

  task automatic push_item(vertex_t v, logic valid, logic [1:0] cls, ref int cnt);
    clip_item_t it;
    if (cnt >= OutCap)
      return;
    it.vtx = v;
    it.valid = valid;
    it.cls = cls;
    it.last = 1'b0;
    pending_items.push_back(it);
    cnt++;
  endtask

  // Loads one vertex into the prediction; on a closing vertex it queues the
  // items the clipper must emit for the whole polygon.
  task automatic clip_vertex(vertex_t v, logic last);
    logic signed [67:0] d, thr, d1, d2, dd;
    logic [30:0] t;
    logic [1:0] cls;
    vertex_t iv;
    int cnt, prv;
    if (ring_count < MaxVerts) begin
      d = $signed(v.x) * plane_nx + $signed(v.y) * plane_ny + $signed(v.z) * plane_nz
          - ($signed(plane_off) <<< 16);
      thr = {36'd0, plane_thr, 16'd0};
      ring_vtx[ring_count] = v;
      ring_dist[ring_count] = d;
      ring_side[ring_count] = (d >= 0);
      if (d > thr) any_front = 1'b1;
      if (d < -thr) any_back = 1'b1;
      ring_count++;
    end
    if (!last)
      return;
    cnt = 0;
    if (!any_front) cls = any_back ? ClsBack : ClsCoplanar;
    else cls = any_back ? ClsSplit : ClsFront;
    if (cls == ClsBack) begin
      push_item('0, 1'b0, ClsBack, cnt);
    end else if (cls != ClsSplit) begin
      for (int i = 0; i < ring_count; i++) push_item(ring_vtx[i], 1'b1, cls, cnt);
    end else begin
      splits_seen++;
      prv = ring_count - 1;
      for (int i = 0; i < ring_count; i++) begin
        if (ring_side[i] != ring_side[prv]) begin
          d1 = ring_dist[prv];
          d2 = ring_dist[i];
          dd = d1 - d2;
          t = frac_of(d1[67] ? -d1 : d1, dd[67] ? -dd : dd);
          iv.x = blend(ring_vtx[prv].x, ring_vtx[i].x, t);
          iv.y = blend(ring_vtx[prv].y, ring_vtx[i].y, t);
          iv.z = blend(ring_vtx[prv].z, ring_vtx[i].z, t);
          iv.u = blend(ring_vtx[prv].u, ring_vtx[i].u, t);
          iv.v = blend(ring_vtx[prv].v, ring_vtx[i].v, t);
          iv.idx = ring_vtx[i].idx;
          push_item(iv, 1'b1, ClsSplit, cnt);
          if (!ring_side[prv]) push_item(ring_vtx[i], 1'b1, ClsSplit, cnt);
        end else if (ring_side[i]) begin
          push_item(ring_vtx[i], 1'b1, ClsSplit, cnt);
        end
        prv = i;
      end
    end
    if (cnt > 0) pending_items[$].last = 1'b1;
    ring_count = 0;
    any_front = 1'b0;
    any_back = 1'b0;
  endtask

  // Register write through the configuration channel, mirrored in the prediction.
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (addr)
      RegNormalX: plane_nx = value[17:0];
      RegNormalY: plane_ny = value[17:0];
      RegNormalZ: plane_nz = value[17:0];
      RegOffset:  plane_off = value;
      RegThresh:  plane_thr = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                           logic [31:0] off, logic [31:0] thr);
    write_reg(RegNormalX, nx);
    write_reg(RegNormalY, ny);
    write_reg(RegNormalZ, nz);
    write_reg(RegOffset, off);
    write_reg(RegThresh, thr);
  endtask

  // Blocks until every predicted item has come back, then lets the
  // sequencer settle before registers change.
  task automatic drain();
    while (pending_items.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_vertex(vertex_t v, logic last);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    clip_vertex(v, last);
    if (last) polygons_sent++;
  endtask

  function automatic vertex_t rand_vertex(int span);
    vertex_t v;
    if (span == 0) begin
      v = {$urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    end else begin
      v.x = $signed($urandom_range(0, 2 * span)) - span;
      v.y = $signed($urandom_range(0, 2 * span)) - span;
      v.z = $signed($urandom_range(0, 2 * span)) - span;
      v.u = $urandom;
      v.v = $urandom;
      v.idx = 16'($urandom);
    end
    return v;
  endfunction

  task automatic send_polygon(int nverts, int span);
    for (int i = 0; i < nverts; i++) send_vertex(rand_vertex(span), i == nverts - 1);
  endtask

  // Result side: random stalls, and one long hold-off asked by the stimulus.
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(5, 30)) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Each accepted result item is compared with the oldest prediction.
  always @(posedge clk) begin
    clip_item_t exp_item;
    vertex_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_items.size() == 0) begin
        $error("unexpected result item, x=%h idx=%h", got.x, got.idx);
        error_count++;
      end else begin
        exp_item = pending_items.pop_front();
        items_checked++;
        if (got.x !== exp_item.vtx.x) begin
          $error("out_x: expected %h, got %h", exp_item.vtx.x, got.x); error_count++;
        end
        if (got.y !== exp_item.vtx.y) begin
          $error("out_y: expected %h, got %h", exp_item.vtx.y, got.y); error_count++;
        end
        if (got.z !== exp_item.vtx.z) begin
          $error("out_z: expected %h, got %h", exp_item.vtx.z, got.z); error_count++;
        end
        if (got.u !== exp_item.vtx.u) begin
          $error("out_u: expected %h, got %h", exp_item.vtx.u, got.u); error_count++;
        end
        if (got.v !== exp_item.vtx.v) begin
          $error("out_v: expected %h, got %h", exp_item.vtx.v, got.v); error_count++;
        end
        if (got.idx !== exp_item.vtx.idx) begin
          $error("out_index: expected %h, got %h", exp_item.vtx.idx, got.idx);
          error_count++;
        end
        if (out_tuser[0] !== exp_item.valid) begin
          $error("vertex_valid: expected %b, got %b", exp_item.valid, out_tuser[0]);
          error_count++;
        end
        if (out_tuser[2:1] !== exp_item.cls) begin
          $error("classification: expected %0d, got %0d", exp_item.cls, out_tuser[2:1]);
          error_count++;
        end
        if (out_tlast !== exp_item.last) begin
          $error("last_out: expected %b, got %b", exp_item.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles without any handshake ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Directed table: one vertex per row. The plane is the reset one, z = 0
  // with tolerance 0.1, so the side follows pos_z alone.
  vert_in_t directed_rows[] = '{
    // Plane-adjacent triangle: coplanar, echoed unchanged.
    '{'{16'h0001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0},
    '{'{16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h00001000, 32'h00010000, 32'h0}, 1'b0},
    '{'{16'h0003, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFF000, 32'h0, 32'h00010000}, 1'b1},
    // Entirely behind: the single empty marker.
    '{'{16'h0004, 32'h1, 32'h1, 32'hFFFE0000, 32'h5, 32'h5}, 1'b0},
    '{'{16'h0005, 32'h2, 32'h2, 32'h80000000, 32'h6, 32'h6}, 1'b1},
    // Entirely in front, single vertex.
    '{'{16'h0006, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1},
    // Split with crossings at the extremes of z.
    '{'{16'h0007, 32'h00010000, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF}, 1'b0},
    '{'{16'h0008, 32'h00020000, 32'h0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000}, 1'b0},
    '{'{16'h0009, 32'h00030000, 32'h00010000, 32'h00020000, 32'h0, 32'h0}, 1'b1},
    // Two-vertex split.
    '{'{16'h000A, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0}, 1'b0},
    '{'{16'h000B, 32'h00040000, 32'h0, 32'hFFFF0000, 32'h00040000, 32'h0}, 1'b1}
  };

  initial begin
    vertex_t v;
    error_count = 0; items_checked = 0; idle_cycles = 0;
    polygons_sent = 0; splits_seen = 0; long_hold = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0;
    cfg_valid = 1'b0; cfg_addr = RegNormalX; cfg_data = '0;
    plane_nx = 0; plane_ny = 0; plane_nz = 18'sd65536; plane_off = 0; plane_thr = 16'd6554;
    ring_count = 0; any_front = 1'b0; any_back = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed polygons; the item count of the coplanar one is also checked by hand.
    for (int r = 0; r < directed_rows.size(); r++) begin
      if (r == 3) begin
        in_tvalid <= 1'b0;
        drain();
        if (items_checked != 3) begin
          $error("coplanar count: expected 3, got %0d", items_checked); error_count++;
        end
      end
      send_vertex(directed_rows[r].vtx, directed_rows[r].last);
    end
    in_tvalid <= 1'b0;
    drain();

    // Overlong polygon: vertices past the store depth are dropped, and a zigzag
    // ring gives a crossing on every edge.
    for (int i = 0; i < 20; i++) begin
      v = rand_vertex(1 << 20);
      v.z = (i % 2) ? 32'hFFF00000 : 32'h00100000;
      send_vertex(v, i == 19);
    end
    in_tvalid <= 1'b0;
    drain();

    // Extreme, random and ordinary plane settings, then random polygons under each.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_plane(32'h1FFFF, 32'h20000, 32'h10000, 32'h7FFFFFFF, 16'hFFFF);
        1: set_plane(32'h20000, 32'h1FFFF, 32'h20000, 32'h80000000, 16'h0000);
        2: set_plane(32'h0B505, 32'h0B505, 32'h0, 32'h0, 16'h0100);
        3: set_plane($urandom, $urandom, $urandom, $urandom_range(0, 65535), $urandom);
        4: set_plane($urandom, $urandom, $urandom, $urandom, $urandom);
        default: set_plane(32'h0, 32'h10000, 32'h0, 32'hFFFF8000, 16'd6554);
      endcase
      for (int p = 0; p < 6; p++) begin
        if (phase == 1 && p == 2) long_hold = 1'b1;
        if ($urandom_range(0, 7) == 0)
          send_polygon($urandom_range(1, 18), 0);
        else
          send_polygon($urandom_range(2, 6), (phase < 2) ? 0 : (1 << $urandom_range(4, 30)));
      end
      // A register write between vertices of one polygon only affects later vertices.
      if (phase == 4) begin
        send_vertex(rand_vertex(1 << 18), 1'b0);
        in_tvalid <= 1'b0;
        drain();
        write_reg(RegOffset, $urandom);
        send_polygon(3, 1 << 18);
      end
      in_tvalid <= 1'b0;
      drain();
    end

    // End of run: nothing outstanding, let the sequencer settle, then report.
    repeat (100) @(posedge clk);
    $display("covered %0d polygons, %0d splits, %0d result items checked",
             polygons_sent, splits_seen, items_checked);
    if (error_count == 0 && pending_items.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
